@@ design/hkrd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_pkg: shared constants and helpers for the keyboard report differ
// Report geometry, event kind codes and the US-layout usage-to-ASCII map.
// ----------------------------------------------------------------------------
package hkrd_pkg;

  // Bytes of a report that are tracked; later bytes are ignored.
  localparam int REPORT_BYTES = 64;
  // Position counter must hold REPORT_BYTES itself (saturation value).
  localparam int POS_W  = $clog2(REPORT_BYTES + 1);
  localparam int ADDR_W = $clog2(REPORT_BYTES);

  localparam int LIMIT_W = 7;
  localparam logic [LIMIT_W-1:0] EVENT_LIMIT_RESET = 7'd63;

  // Byte positions with a fixed role
  localparam logic [POS_W-1:0] POS_MODIFIER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FIRST_KEY = POS_W'(2);
  localparam logic [POS_W-1:0] POS_END = POS_W'(REPORT_BYTES);

  // Event kinds
  localparam logic KIND_PRESS   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  // Modifier byte shift bits
  localparam int MOD_LSHIFT_BIT = 1;
  localparam int MOD_RSHIFT_BIT = 5;

  // Usage code ranges
  localparam logic [7:0] KEY_A     = 8'h04;
  localparam logic [7:0] KEY_Z     = 8'h1D;
  localparam logic [7:0] KEY_1     = 8'h1E;
  localparam logic [7:0] KEY_0     = 8'h27;

  // US layout: usage code and shift state to 7-bit ASCII, 0 when unmapped.
  function automatic logic [6:0] to_ascii(input logic [7:0] key, input logic shift);
    logic [7:0] off;
    logic [6:0] res;
    off = key - KEY_A;
    res = 7'h00;
    if (key >= KEY_A && key <= KEY_Z) begin
      res = shift ? (7'h41 + off[6:0]) : (7'h61 + off[6:0]);
    end else begin
      case (key)
        8'h1E: res = shift ? 7'h21 : 7'h31;  // ! 1
        8'h1F: res = shift ? 7'h40 : 7'h32;  // @ 2
        8'h20: res = shift ? 7'h23 : 7'h33;  // # 3
        8'h21: res = shift ? 7'h24 : 7'h34;  // $ 4
        8'h22: res = shift ? 7'h25 : 7'h35;  // % 5
        8'h23: res = shift ? 7'h5E : 7'h36;  // ^ 6
        8'h24: res = shift ? 7'h26 : 7'h37;  // & 7
        8'h25: res = shift ? 7'h2A : 7'h38;  // * 8
        8'h26: res = shift ? 7'h28 : 7'h39;  // ( 9
        8'h27: res = shift ? 7'h29 : 7'h30;  // ) 0
        8'h2C: res = 7'h20;                  // space
        8'h2D: res = shift ? 7'h5F : 7'h2D;  // _ -
        8'h2E: res = shift ? 7'h2B : 7'h3D;  // + =
        8'h2F: res = shift ? 7'h7B : 7'h5B;  // { [
        8'h30: res = shift ? 7'h7D : 7'h5D;  // } ]
        8'h31: res = shift ? 7'h7C : 7'h5C;  // | backslash
        8'h33: res = shift ? 7'h3A : 7'h3B;  // : ;
        8'h34: res = shift ? 7'h22 : 7'h27;  // double / single quote
        8'h35: res = shift ? 7'h7E : 7'h60;  // ~ backtick
        8'h36: res = shift ? 7'h3C : 7'h2C;  // < ,
        8'h37: res = shift ? 7'h3E : 7'h2E;  // > .
        8'h38: res = shift ? 7'h3F : 7'h2F;  // ? /
        default: res = 7'h00;
      endcase
    end
    return res;
  endfunction

endpackage

@@ design/hkrd_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_in_if: report byte channel
// Valid/ready channel carrying one report byte and its end marker per item.
// ----------------------------------------------------------------------------
interface hkrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  logic       last_byte;

  modport source (output valid, output report_byte, output last_byte, input ready);
  modport sink   (input valid, input report_byte, input last_byte, output ready);
endinterface

@@ design/hkrd_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_out_if: key event channel
// Valid/ready channel carrying one result item per report byte.
// ----------------------------------------------------------------------------
interface hkrd_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic       event_kind;
  logic [7:0] key_code;
  logic [6:0] ascii_code;
  logic       report_end;
  logic [6:0] events_so_far;

  modport source (
    output valid, output event_valid, output event_kind, output key_code,
    output ascii_code, output report_end, output events_so_far, input ready
  );
  modport sink (
    input valid, input event_valid, input event_kind, input key_code,
    input ascii_code, input report_end, input events_so_far, output ready
  );
endinterface

@@ design/hkrd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hkrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/hid_keyboard_report_differ.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_differ: keyboard report to key press/release events
// Compares each key slot of a keyboard report (bytes 2 to 63) with the previous report.
// ----------------------------------------------------------------------------
// Usage:
//   report  - input channel, one report byte per item, modifier byte first,
//             last_byte set on the report's final byte.
//   events  - output channel, exactly one result item per input item; the
//             event fields are zero when event_valid is low.
//   cfg_wr_en/cfg_wr_data - write the per-report event limit (reset 63).
//             Write only while the block is idle.
// An accepted item shows on events in the cycle after it is accepted.
// Throughput is one item per cycle while the receiver takes each item, set
// by the single output register; the slot store is read in advance at the
// next byte position, so its registered read never stalls the flow.
// When the receiver stalls, the output register holds its item and ready
// on the report channel drops until the item is taken.
// Reset (synchronous, active high) clears the position, shift flag, event
// count and all slot valid bits and returns the limit to 63, so every slot
// of the previous report reads as zero; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module hid_keyboard_report_differ (
  input  logic                            clk,
  input  logic                            rst,
  hkrd_in_if.sink                         report,
  hkrd_out_if.source                      events,
  input  logic                            cfg_wr_en,
  input  logic [hkrd_pkg::LIMIT_W-1:0]    cfg_wr_data
);

  // Control state
  logic [hkrd_pkg::POS_W-1:0]        byte_pos, byte_pos_next;
  logic                              shift_held, shift_held_next;
  logic [hkrd_pkg::LIMIT_W-1:0]      event_count, event_count_next;
  logic [hkrd_pkg::LIMIT_W-1:0]      event_limit;
  logic [hkrd_pkg::REPORT_BYTES-1:0] slot_valid;

  // Output register
  logic                              out_valid;
  logic                              res_event_valid;
  logic                              res_event_kind;
  logic [7:0]                        res_key_code;
  logic [6:0]                        res_ascii_code;
  logic                              res_report_end;
  logic [hkrd_pkg::LIMIT_W-1:0]      res_events_so_far;

  // Datapath
  logic                              accept;
  logic                              in_key_slot;
  logic [hkrd_pkg::ADDR_W-1:0]       slot_addr;
  logic [7:0]                        ram_rd_data;
  logic [7:0]                        old_key;
  logic                              is_press, is_release, fire;
  logic [7:0]                        ev_key;
  logic [hkrd_pkg::LIMIT_W-1:0]      count_inc;

  // Advance whenever the output register is empty or being drained.
  assign report.ready = !out_valid || events.ready;
  assign accept       = report.valid && report.ready;

  assign slot_addr   = byte_pos[hkrd_pkg::ADDR_W-1:0];
  assign in_key_slot = (byte_pos >= hkrd_pkg::POS_FIRST_KEY) && (byte_pos < hkrd_pkg::POS_END);

  // A slot never written since reset reads as zero.
  assign old_key = slot_valid[slot_addr] ? ram_rd_data : 8'h00;

  always_comb begin
    is_release = (report.report_byte == 8'h00) && (old_key != 8'h00);
    is_press   = (report.report_byte != 8'h00) && (old_key == 8'h00);
    // Replaced or unchanged keys give no event; stop at the limit.
    fire       = in_key_slot && (event_count < event_limit) && (is_release || is_press);
    ev_key     = is_release ? old_key : report.report_byte;
    count_inc  = event_count + hkrd_pkg::LIMIT_W'(fire);

    byte_pos_next    = byte_pos;
    shift_held_next  = shift_held;
    event_count_next = event_count;
    if (accept) begin
      if (byte_pos == hkrd_pkg::POS_MODIFIER) begin
        shift_held_next = report.report_byte[hkrd_pkg::MOD_LSHIFT_BIT]
                       || report.report_byte[hkrd_pkg::MOD_RSHIFT_BIT];
      end
      if (report.last_byte) begin
        byte_pos_next    = '0;
        event_count_next = '0;
      end else begin
        event_count_next = count_inc;
        if (byte_pos < hkrd_pkg::POS_END) begin
          byte_pos_next = byte_pos + hkrd_pkg::POS_W'(1);
        end
      end
    end
  end

  // Previous report store: written at the current slot, read ahead at the slot
  // the next item will use.
  hkrd_ram #(
    .WIDTH (8),
    .DEPTH (hkrd_pkg::REPORT_BYTES)
  ) u_prev_report (
    .clk     (clk),
    .wr_en   (accept && in_key_slot),
    .wr_addr (slot_addr),
    .wr_data (report.report_byte),
    .rd_addr (byte_pos_next[hkrd_pkg::ADDR_W-1:0]),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= '0;
      shift_held  <= 1'b0;
      event_count <= '0;
      event_limit <= hkrd_pkg::EVENT_LIMIT_RESET;
      slot_valid  <= '0;
      out_valid   <= 1'b0;
    end else begin
      byte_pos    <= byte_pos_next;
      shift_held  <= shift_held_next;
      event_count <= event_count_next;
      if (cfg_wr_en) begin
        event_limit <= cfg_wr_data;
      end
      if (accept && in_key_slot) begin
        slot_valid[slot_addr] <= 1'b1;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_event_valid   <= fire;
      res_event_kind    <= fire ? (is_release ? hkrd_pkg::KIND_RELEASE : hkrd_pkg::KIND_PRESS)
                                : hkrd_pkg::KIND_PRESS;
      res_key_code      <= fire ? ev_key : 8'h00;
      res_ascii_code    <= fire ? hkrd_pkg::to_ascii(ev_key, shift_held) : 7'h00;
      res_report_end    <= report.last_byte;
      res_events_so_far <= count_inc;
    end
  end

  assign events.valid         = out_valid;
  assign events.event_valid   = res_event_valid;
  assign events.event_kind    = res_event_kind;
  assign events.key_code      = res_key_code;
  assign events.ascii_code    = res_ascii_code;
  assign events.report_end    = res_report_end;
  assign events.events_so_far = res_events_so_far;

endmodule

@@ design/hkrd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_checker: port-level checks for the keyboard report differ
// Watches the event channel; bound to the top level below.
// ----------------------------------------------------------------------------
module hkrd_checker (
  input logic       clk,
  input logic       rst,
  input logic       ev_ch_valid,
  input logic       ev_ch_ready,
  input logic       event_valid,
  input logic       event_kind,
  input logic [7:0] key_code,
  input logic [6:0] ascii_code,
  input logic       report_end,
  input logic [6:0] events_so_far
);

  // Nothing comes out right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !ev_ch_valid)
    else $error("event item valid right after reset");

  // A stalled item holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    ev_ch_valid && !ev_ch_ready |=> ev_ch_valid && $stable(event_valid)
      && $stable(key_code) && $stable(ascii_code) && $stable(report_end)
      && $stable(events_so_far))
    else $error("stalled event item changed");

  // No event: event fields are zero.
  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    ev_ch_valid && !event_valid |-> key_code == 8'h00 && ascii_code == 7'h00
      && event_kind == hkrd_pkg::KIND_PRESS)
    else $error("event fields set without an event");

  // An event always counts itself and names a real key.
  a_event_counted: assert property (@(posedge clk) disable iff (rst)
    ev_ch_valid && event_valid |-> events_so_far != 7'd0 && key_code != 8'h00)
    else $error("event without count or key code");

endmodule

bind hid_keyboard_report_differ hkrd_checker u_hkrd_checker (
  .clk           (clk),
  .rst           (rst),
  .ev_ch_valid   (events.valid),
  .ev_ch_ready   (events.ready),
  .event_valid   (events.event_valid),
  .event_kind    (events.event_kind),
  .key_code      (events.key_code),
  .ascii_code    (events.ascii_code),
  .report_end    (events.report_end),
  .events_so_far (events.events_so_far)
);
